@@ rtl/core/ris_pkg.sv @@
package ris_pkg;

    localparam int MaxOrder = 64;
    localparam int IdxW     = 6;
    localparam int SizeW    = 7;
    localparam int IterW    = 16;
    localparam int DataW    = 64;
    localparam int FracBits = 32;
    localparam int NormW    = 128;
    localparam int TolW     = 34;
    localparam logic [TolW-1:0] TolK = 34'd10000000000;

    localparam logic [SizeW-1:0] SizeReset = 7'd64;
    localparam logic [IterW-1:0] IterReset = 16'd10000;

    localparam logic CfgActiveSize = 1'b0;
    localparam logic CfgMaxIter    = 1'b1;

    typedef enum logic [2:0] {
        FN_WR_MATRIX = 3'd0,
        FN_WR_RHS    = 3'd1,
        FN_WR_X      = 3'd2,
        FN_SOLVE     = 3'd3,
        FN_RD_X      = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BNORM,
        ST_ROW,
        ST_ROW_FIN,
        ST_CHECK,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Control from the sequencer to the cell row.
    typedef struct packed {
        logic              load_x;
        logic [IdxW-1:0]   load_idx;
        logic [DataW-1:0]  load_val;
        logic              rotate;
        logic              update;
        logic [DataW-1:0]  delta;
    } cell_ctrl_t;

    function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                                 input logic [DataW-1:0] b);
        logic [DataW-1:0] s;
        s = a + b;
        if (a[DataW-1] == b[DataW-1] && s[DataW-1] != a[DataW-1])
            s = a[DataW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        return s;
    endfunction

    function automatic logic [DataW-1:0] sat_sub(input logic [DataW-1:0] a,
                                                 input logic [DataW-1:0] b);
        logic [DataW-1:0] s;
        s = a - b;
        if (a[DataW-1] != b[DataW-1] && s[DataW-1] != a[DataW-1])
            s = a[DataW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        return s;
    endfunction

    function automatic logic [DataW-1:0] mag_of(input logic [DataW-1:0] v);
        return v[DataW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ rtl/core/richardson_iteration_solver.sv @@
// Channel | Direction | Beat contents
// s_axis  | in        | tdata: func[2:0] row[8:3] col[14:9] value[78:15], zero fill to 80
// m_axis  | out       | tdata: read_value[63:0] converged[64] iterations[80:65] status[81]
// cfg     | in        | cfg_index selects active_size (0) or max_iterations (1)
//
// Load, read and unknown beats pass a pending flag into the result register; the
// next beat is taken once none is pending and the result register is empty or
// is being drained. A solve first forms the right-hand side norm, then per pass
// the products and residuals (each product or square is four 32x32 phases), the
// stop test and the step, which a restoring divide sets; the converging pass
// skips the step. Input stalls during a solve. Reset is synchronous and active
// low; the solution row clears to zero.
module richardson_iteration_solver
    import ris_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // func, row, col, value from bit 0 up
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // read_value, converged, iterations, status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [SizeW-1:0] size_reg;
    logic [IterW-1:0] maxit_reg;
    logic [IterW-1:0] iter_reg;
    logic             conv_reg;

    // Beat fields.
    logic [2:0]       in_func;
    logic [IdxW-1:0]  in_row, in_col;
    logic [DataW-1:0] in_val;
    assign in_func = s_axis_tdata[2:0];
    assign in_row  = s_axis_tdata[8:3];
    assign in_col  = s_axis_tdata[14:9];
    assign in_val  = s_axis_tdata[78:15];

    // Effective order: zero means one; the field cannot exceed the maximum
    // other than at 65..127 which clamp to 64.
    logic [SizeW-1:0] n_eff;
    assign n_eff = (size_reg == '0) ? 7'd1 :
                   (size_reg > 7'(MaxOrder)) ? 7'(MaxOrder) : size_reg;

    // Memories.
    logic [DataW-1:0] mat_mem [MaxOrder*MaxOrder];
    logic [DataW-1:0] rhs_mem [MaxOrder];
    logic [DataW-1:0] res_mem [MaxOrder];
    logic [DataW-1:0] mat_q, rhs_q, res_q;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic [IdxW-1:0] i_reg, j_reg;
    logic [1:0]      sub_reg;   // sub-phase inside a step
    logic [IdxW-1:0] last_idx;
    assign last_idx = IdxW'(n_eff - 7'd1);

    logic row_ok, col_ok;
    assign row_ok = {1'b0, in_row} < n_eff;
    assign col_ok = {1'b0, in_col} < n_eff;

    // Cell row: cells 0..MaxOrder-1, rotated over the active n only. Cells at
    // or beyond n hold their entries so that a later larger order sees them.
    cell_ctrl_t       cctl;
    logic [DataW-1:0] xs [MaxOrder];
    logic [DataW-1:0] x_new;

    genvar g;
    generate
        for (g = 0; g < MaxOrder; g++) begin : g_cell
            logic [DataW-1:0] pv;
            if (g == MaxOrder - 1) begin : g_end
                assign pv = (n_eff == 7'(MaxOrder)) ?
                            (cctl.update ? x_new : xs[0]) : xs[g];
            end else begin : g_mid
                assign pv = (7'(g) > n_eff - 7'd1) ? xs[g] :
                            (7'(g) == n_eff - 7'd1) ?
                            (cctl.update ? x_new : xs[0]) : xs[g+1];
            end
            ris_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .my_idx  (IdxW'(g)),
                .ctrl    (cctl),
                .prev_x  (pv),
                .x_out   (xs[g])
            );
        end
    endgenerate

    // Product unit and norm units.
    logic mac_clr, mac_en, mac_busy;
    logic [DataW-1:0] mac_sum;
    logic sq_clr, sq_en, sq_busy;
    logic [DataW-1:0] sq_in;
    logic [NormW-1:0] sq_norm;
    logic [NormW-1:0] nb_reg;

    ris_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .clear(mac_clr), .en(mac_en),
        .a(mat_q), .x(xs[0]), .busy(mac_busy), .sum(mac_sum)
    );

    ris_sqacc u_sq (
        .aclk(aclk), .aresetn(aresetn), .clear(sq_clr), .en(sq_en),
        .v(sq_in), .busy(sq_busy), .norm(sq_norm)
    );

    // Step divider: |r| / (100 n) by restoring division, one bit a cycle.
    logic [6:0]       dv_cnt_reg;
    logic [DataW-1:0] dv_q_reg;
    logic [DataW-1:0] dv_r_reg;
    logic             dv_neg_reg;
    logic [13:0]      divisor;
    logic [DataW:0]   dv_trial;
    assign divisor  = 14'(n_eff) * 14'd100;
    assign dv_trial = {dv_r_reg, dv_q_reg[DataW-1]} - {51'd0, divisor};

    // Convergence compare: nr * 1e10 < nb. The product is built one 32-bit
    // limb of nr per cycle, using i_reg as the limb counter.
    logic [NormW+TolW-1:0] tol_prod_reg;
    logic [31:0]           tol_limb;
    logic [65:0]           tol_pp;
    logic [NormW+TolW-1:0] tol_sh;
    assign tol_limb = sq_norm[{i_reg[1:0], 5'd0} +: 32];
    assign tol_pp   = {34'd0, tol_limb} * {32'd0, TolK};
    assign tol_sh   = {96'd0, tol_pp} << {i_reg[1:0], 5'd0};

    // Result register.
    logic        out_valid_reg;
    logic [87:0] out_data_reg;
    logic        done_pulse;
    logic [DataW-1:0] rd_val_reg;
    logic        rd_pend_reg;
    logic        stat_reg;

    assign s_axis_tready = (state_reg == ST_IDLE) && !rd_pend_reg &&
                           (!out_valid_reg || m_axis_tready);
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && in_func == FN_SOLVE) state_next = ST_BNORM;
            ST_BNORM:
                if (sub_reg == 2'd2 && !sq_busy && i_reg == last_idx)
                    state_next = (maxit_reg == '0) ? ST_RESULT : ST_ROW;
            ST_ROW:
                if (sub_reg == 2'd2 && !mac_busy && j_reg == last_idx)
                    state_next = ST_ROW_FIN;
            ST_ROW_FIN:
                if (sub_reg == 2'd2 && !sq_busy)
                    state_next = (i_reg == last_idx) ? ST_CHECK : ST_ROW;
            ST_CHECK:
                if (sub_reg == 2'd1) begin
                    if (tol_prod_reg < {34'd0, nb_reg}) state_next = ST_RESULT;
                    else state_next = ST_UPDATE;
                end
            ST_UPDATE:
                if (sub_reg == 2'd2 && dv_cnt_reg == '0 && i_reg == last_idx)
                    state_next = (iter_reg == maxit_reg) ? ST_RESULT : ST_ROW;
            ST_RESULT:
                if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs toward datapath.
    always_comb begin
        cctl          = '0;
        cctl.load_idx = in_row;
        cctl.load_val = in_val;
        cctl.load_x   = accept && in_func == FN_WR_X && row_ok;
        mac_clr = 1'b0;
        mac_en  = 1'b0;
        sq_clr  = 1'b0;
        sq_en   = 1'b0;
        sq_in   = rhs_q;
        x_new   = sat_sub(xs[0], dv_neg_reg ? (~dv_q_reg + 1'b1) : dv_q_reg);
        done_pulse = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                sq_clr = accept && in_func == FN_SOLVE;
            end
            ST_BNORM: begin
                sq_en = sub_reg == 2'd1;
            end
            ST_ROW: begin
                // The residual norm starts from zero at the top of each pass.
                sq_clr  = i_reg == '0 && j_reg == '0 && sub_reg == 2'd0;
                mac_clr = j_reg == '0 && sub_reg == 2'd0;
                mac_en  = sub_reg == 2'd1;
                cctl.rotate = sub_reg == 2'd2 && !mac_busy;
            end
            ST_ROW_FIN: begin
                sq_in = sat_sub(mac_sum, rhs_q);
                sq_en = sub_reg == 2'd1;
            end
            ST_UPDATE: begin
                cctl.update = sub_reg == 2'd2 && dv_cnt_reg == '0;
            end
            ST_RESULT: begin
                done_pulse = !out_valid_reg || m_axis_tready;
            end
            default: ;
        endcase
    end

    // Memory ports.
    logic [IdxW-1:0] mrow, mcol;
    always_comb begin
        mrow = i_reg;
        mcol = j_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept && in_func == FN_WR_MATRIX && row_ok && col_ok)
            mat_mem[{in_row, in_col}] <= in_val;
        mat_q <= mat_mem[{mrow, mcol}];
    end

    always_ff @(posedge aclk) begin
        if (accept && in_func == FN_WR_RHS && row_ok)
            rhs_mem[in_row] <= in_val;
        rhs_q <= rhs_mem[mrow];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROW_FIN && sub_reg == 2'd1)
            res_mem[i_reg] <= sq_in;
        res_q <= res_mem[mrow];
    end

    // Sequencer counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            iter_reg  <= '0;
            conv_reg  <= 1'b0;
            size_reg  <= SizeReset;
            maxit_reg <= IterReset;
            dv_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CfgActiveSize) size_reg <= cfg_data[SizeW-1:0];
                else                            maxit_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    sub_reg <= '0;
                    i_reg   <= '0;
                    j_reg   <= '0;
                    if (accept && in_func == FN_SOLVE) begin
                        iter_reg <= '0;
                        conv_reg <= 1'b0;
                    end
                end
                ST_BNORM: begin
                    // 0: address out, 1: data ready, start square, 2: wait
                    if (sub_reg != 2'd2) sub_reg <= sub_reg + 2'd1;
                    else if (!sq_busy) begin
                        sub_reg <= '0;
                        if (i_reg == last_idx) i_reg <= '0;
                        else i_reg <= i_reg + 1'b1;
                    end
                end
                ST_ROW: begin
                    if (sub_reg != 2'd2) sub_reg <= sub_reg + 2'd1;
                    else if (!mac_busy) begin
                        sub_reg <= '0;
                        if (j_reg == last_idx) j_reg <= '0;
                        else j_reg <= j_reg + 1'b1;
                    end
                end
                ST_ROW_FIN: begin
                    if (sub_reg != 2'd2) sub_reg <= sub_reg + 2'd1;
                    else if (!sq_busy) begin
                        sub_reg <= '0;
                        if (i_reg == last_idx) begin
                            i_reg    <= '0;
                            iter_reg <= iter_reg + 1'b1;
                        end else i_reg <= i_reg + 1'b1;
                    end
                end
                ST_CHECK: begin
                    // 0: one limb of the scaled norm per cycle, 1: compare
                    if (sub_reg == 2'd0) begin
                        if (i_reg == IdxW'(NormW/32 - 1)) begin
                            sub_reg <= 2'd1;
                            i_reg   <= '0;
                        end else i_reg <= i_reg + 1'b1;
                    end else begin
                        sub_reg <= '0;
                        if (tol_prod_reg < {34'd0, nb_reg}) conv_reg <= 1'b1;
                    end
                end
                ST_UPDATE: begin
                    if (sub_reg == 2'd0) sub_reg <= 2'd1;
                    else if (sub_reg == 2'd1) begin
                        sub_reg    <= 2'd2;
                        dv_cnt_reg <= 7'd64;
                    end else if (dv_cnt_reg != '0) begin
                        dv_cnt_reg <= dv_cnt_reg - 1'b1;
                    end else begin
                        sub_reg <= '0;
                        if (i_reg == last_idx) i_reg <= '0;
                        else i_reg <= i_reg + 1'b1;
                    end
                end
                default: sub_reg <= '0;
            endcase
        end
    end

    // Norm of b is captured once; the scaled residual norm is summed after a pass.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_BNORM && state_next != ST_BNORM)
            nb_reg <= sq_norm;
        if (state_reg == ST_ROW_FIN && state_next == ST_CHECK)
            tol_prod_reg <= '0;
        else if (state_reg == ST_CHECK && sub_reg == 2'd0)
            tol_prod_reg <= tol_prod_reg + tol_sh;
    end

    // Divider datapath.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE && sub_reg == 2'd1) begin
            dv_q_reg   <= mag_of(res_q);
            dv_r_reg   <= '0;
            dv_neg_reg <= res_q[DataW-1];
        end else if (state_reg == ST_UPDATE && sub_reg == 2'd2 && dv_cnt_reg != '0) begin
            if (!dv_trial[DataW]) begin
                dv_r_reg <= dv_trial[DataW-1:0];
                dv_q_reg <= {dv_q_reg[DataW-2:0], 1'b1};
            end else begin
                dv_r_reg <= {dv_r_reg[DataW-2:0], dv_q_reg[DataW-1]};
                dv_q_reg <= {dv_q_reg[DataW-2:0], 1'b0};
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end else begin
            if (rd_pend_reg || done_pulse) out_valid_reg <= 1'b1;
            else if (m_axis_tready)        out_valid_reg <= 1'b0;
            if (rd_pend_reg)                         rd_pend_reg <= 1'b0;
            else if (accept && in_func != FN_SOLVE)  rd_pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (in_func)
                FN_WR_MATRIX: stat_reg <= !(row_ok && col_ok);
                FN_WR_RHS, FN_WR_X, FN_RD_X: stat_reg <= !row_ok;
                default: stat_reg <= 1'b0;
            endcase
            rd_val_reg <= (in_func == FN_RD_X && row_ok) ? xs[in_row] : '0;
        end
        if (rd_pend_reg)
            out_data_reg <= {6'd0, stat_reg, iter_reg, conv_reg, rd_val_reg};
        if (done_pulse)
            out_data_reg <= {6'd0, 1'b0, iter_reg, conv_reg, 64'd0};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/core/ris_cell.sv @@
module ris_cell
    import ris_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IdxW-1:0]  my_idx,
    input  cell_ctrl_t       ctrl,
    input  logic [DataW-1:0] prev_x,
    output logic [DataW-1:0] x_out
);

    logic [DataW-1:0] x_reg, x_next;

    // Each cell holds one solution entry; the row rotates so that cell zero
    // presents x[j] at column step j, and one update shifts in x minus the divided step.
    always_comb begin
        x_next = x_reg;
        if (ctrl.load_x && ctrl.load_idx == my_idx)
            x_next = ctrl.load_val;
        else if (ctrl.rotate)
            x_next = prev_x;
        else if (ctrl.update)
            x_next = prev_x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) x_reg <= '0;
        else          x_reg <= x_next;
    end

    assign x_out = x_reg;

endmodule

@@ rtl/core/ris_mac.sv @@
module ris_mac
    import ris_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             en,
    input  logic [DataW-1:0] a,
    input  logic [DataW-1:0] x,
    output logic             busy,
    output logic [DataW-1:0] sum
);

    // Four 32x32 partial products in turn, then scale and add.
    logic [1:0]          ph_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic [DataW-1:0]    am_reg, xm_reg;
    logic [NormW-1:0]    acc_reg;
    logic [DataW-1:0]    sum_reg;
    logic [63:0]         pp;
    logic [NormW-1:0]    pp_sh;
    logic [NormW-1:0]    acc_n;
    logic [DataW-1:0]    q;
    logic [DataW-1:0]    term;
    logic [DataW-1:0]    lim;

    always_comb begin
        unique case (ph_reg)
            2'd0: pp = am_reg[31:0]  * xm_reg[31:0];
            2'd1: pp = am_reg[31:0]  * xm_reg[63:32];
            2'd2: pp = am_reg[63:32] * xm_reg[31:0];
            default: pp = am_reg[63:32] * xm_reg[63:32];
        endcase
        unique case (ph_reg)
            2'd0: pp_sh = {64'd0, pp};
            2'd3: pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        acc_n = acc_reg + pp_sh;
        lim   = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        q     = acc_n[FracBits +: DataW];
        if (acc_n[NormW-1 -: (NormW-DataW-FracBits)] != '0 || q > lim) q = lim;
        term  = neg_reg ? (~q + 1'b1) : q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
        end else if (en) begin
            busy_reg <= 1'b1;
            ph_reg   <= '0;
        end else if (busy_reg) begin
            ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd3) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) sum_reg <= '0;
        if (en) begin
            am_reg  <= mag_of(a);
            xm_reg  <= mag_of(x);
            neg_reg <= a[DataW-1] ^ x[DataW-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_n;
            if (ph_reg == 2'd3) sum_reg <= sat_add(sum_reg, term);
        end
    end

    assign busy = busy_reg | en;
    assign sum  = sum_reg;

endmodule

@@ rtl/core/ris_sqacc.sv @@
module ris_sqacc
    import ris_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             en,
    input  logic [DataW-1:0] v,
    output logic             busy,
    output logic [NormW-1:0] norm
);

    // Saturating sum of squares; each square takes four partial products.
    logic [1:0]       ph_reg;
    logic             busy_reg;
    logic [DataW-1:0] m_reg;
    logic [NormW-1:0] sq_reg;
    logic [NormW-1:0] norm_reg;
    logic [63:0]      pp;
    logic [NormW-1:0] pp_sh;
    logic [NormW-1:0] sq_n;
    logic [NormW:0]   tot;

    always_comb begin
        unique case (ph_reg)
            2'd0: pp = m_reg[31:0]  * m_reg[31:0];
            2'd1: pp = m_reg[31:0]  * m_reg[63:32];
            2'd2: pp = m_reg[63:32] * m_reg[31:0];
            default: pp = m_reg[63:32] * m_reg[63:32];
        endcase
        unique case (ph_reg)
            2'd0: pp_sh = {64'd0, pp};
            2'd3: pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        sq_n = sq_reg + pp_sh;
        tot  = {1'b0, norm_reg} + {1'b0, sq_n};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
        end else if (en) begin
            busy_reg <= 1'b1;
            ph_reg   <= '0;
        end else if (busy_reg) begin
            ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd3) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) norm_reg <= '0;
        if (en) begin
            m_reg  <= mag_of(v);
            sq_reg <= '0;
        end else if (busy_reg) begin
            sq_reg <= sq_n;
            if (ph_reg == 2'd3)
                norm_reg <= tot[NormW] ? {NormW{1'b1}} : tot[NormW-1:0];
        end
    end

    assign busy = busy_reg | en;
    assign norm = norm_reg;

endmodule

@@ rtl/core/ris_checker.sv @@
module ris_checker
    import ris_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[87:82] == 6'd0)
        else $error("padding bits set");

    a_conv_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[81] |-> m_axis_tdata[63:0] == 64'd0)
        else $error("ignored beat returned data");

    a_no_accept_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken before result formed");

endmodule

bind richardson_iteration_solver ris_checker u_ris_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
